FILE: rtl/tlwm_pkg.sv
// Shared constants and types for the task load window monitor.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none
package tlwm_pkg;
   localparam int TASK_SLOTS_DEF   = 12;
   localparam int WINDOW_DEPTH_DEF = 5;
   localparam int COUNTER_BITS_DEF = 32;

   localparam int ID_W    = 16;
   localparam int FIELD_W = 32;
   localparam int LOAD_W  = 10;
   localparam int REQ_W   = 80;   // id, runtime, total
   localparam int RSP_W   = 48;   // id, window, peak, average, pad

   localparam logic [LOAD_W-1:0] FULL_SCALE = LOAD_W'(1000);

   // divider status back to the sequencer
   typedef struct packed {
      logic              done;
      logic [LOAD_W-1:0] q;
   } div_rsp_type;

   // slot lookup status
   typedef struct packed {
      logic hit;
      logic full;
   } slot_rsp_type;
endpackage
`default_nettype wire

FILE: rtl/tlwm_div.sv
// Bit-serial permille divider: floor(part*1000/whole), saturated at 1000.
// Depends on tlwm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlwm_div #(
   parameter int COUNTER_BITS = tlwm_pkg::COUNTER_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [COUNTER_BITS-1:0]  part,
   input  wire logic [COUNTER_BITS-1:0]  whole,
   output tlwm_pkg::div_rsp_type         rsp
);
   import tlwm_pkg::*;

   localparam int CB = COUNTER_BITS;
   localparam int NW = CB + LOAD_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [CB-1:0]     rem_ff, rem_in;
   logic [CB-1:0]     whole_ff, whole_in;
   logic [LOAD_W-1:0] low_ff, low_in;
   logic [LOAD_W-1:0] q_ff, q_in;

   logic [NW-1:0]     prod;
   logic [CB:0]       trial;
   logic              fits;

   // part*1000 = part*1024 - part*16 - part*8
   assign prod = {part, LOAD_W'(0)} - NW'({part, 4'b0}) - NW'({part, 3'b0});
   assign trial = {rem_ff, low_ff[LOAD_W-1]};
   assign fits  = trial >= {1'b0, whole_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      whole_in = whole_ff;
      low_in   = low_ff;
      q_in     = q_ff;
      if (start) begin
         whole_in = whole;
         if (whole == '0) begin
            q_in    = '0;
            done_in = 1'b1;
         end else if (part >= whole) begin
            q_in    = FULL_SCALE;
            done_in = 1'b1;
         end else begin
            // quotient < 1024, so the top bits already sit below whole
            rem_in  = prod[NW-1:LOAD_W];
            low_in  = prod[LOAD_W-1:0];
            q_in    = '0;
            cnt_in  = 4'(LOAD_W);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = fits ? CB'(trial - {1'b0, whole_ff}) : trial[CB-1:0];
         low_in = {low_ff[LOAD_W-2:0], 1'b0};
         q_in   = {q_ff[LOAD_W-2:0], fits};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      whole_ff <= whole_in;
      low_ff   <= low_in;
      q_ff     <= q_in;
   end

   assign rsp.done = done_ff;
   assign rsp.q    = q_ff;
endmodule
`default_nettype wire

FILE: rtl/tlwm_slots.sv
// Task id to slot table: parallel match, append on miss while room remains.
// Depends on tlwm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlwm_slots #(
   parameter  int TASK_SLOTS = tlwm_pkg::TASK_SLOTS_DEF,
   localparam int SlotW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1,
   localparam int CntW  = $clog2(TASK_SLOTS + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [tlwm_pkg::ID_W-1:0]   lookup_id,
   input  wire logic                        add,
   output tlwm_pkg::slot_rsp_type           rsp,
   output logic [SlotW-1:0]                 idx,
   output logic [CntW-1:0]                  used
);
   import tlwm_pkg::*;

   logic [ID_W-1:0] ids_ff [TASK_SLOTS];
   logic [CntW-1:0] used_ff;
   logic            hit;
   logic [SlotW-1:0] match;

   always_comb begin
      hit   = 1'b0;
      match = '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         if (!hit && (i < int'(used_ff)) && (ids_ff[i] == lookup_id)) begin
            hit   = 1'b1;
            match = SlotW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         for (int i = 0; i < TASK_SLOTS; i++) ids_ff[i] <= '0;
      end else if (add) begin
         ids_ff[used_ff[SlotW-1:0]] <= lookup_id;
         used_ff <= used_ff + CntW'(1);
      end
   end

   assign rsp.hit  = hit;
   assign rsp.full = (used_ff == CntW'(TASK_SLOTS));
   assign idx      = hit ? match : used_ff[SlotW-1:0];
   assign used     = used_ff;
endmodule
`default_nettype wire

FILE: rtl/task_load_window_monitor_core.sv
// Task load window monitor: per-task window, peak and average load in permille.
// A beat with a row: lookup, two snapshot reads, three starts, three bit-serial
// divisions (cut short on a zero or saturated load), commit. A beat with no row
// goes from lookup straight to commit, with no reads or divisions.
// One item in flight; a row waits in the output register while the next beat
// runs, and a commit stalls only while that register is still full.
// Synchronous active-high reset clears the slot table, ring and all history.
`timescale 1ns / 1ps
`default_nettype none
module task_load_window_monitor_core #(
   parameter int TASK_SLOTS   = tlwm_pkg::TASK_SLOTS_DEF,
   parameter int WINDOW_DEPTH = tlwm_pkg::WINDOW_DEPTH_DEF,
   parameter int COUNTER_BITS = tlwm_pkg::COUNTER_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // task_id[15:0], task_runtime[47:16], sample_total[79:48]
   input  wire logic [tlwm_pkg::REQ_W-1:0]  req_tdata,
   input  wire logic                        req_tlast,      // last_in_sample
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // row_task_id[15:0], window_permille[25:16], peak_permille[35:26],
   // average_permille[45:36], zero pad[47:46]
   output logic [tlwm_pkg::RSP_W-1:0]       rsp_tdata
);
   import tlwm_pkg::*;

   localparam int CB    = COUNTER_BITS;
   localparam int SlotW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CntW  = $clog2(TASK_SLOTS + 1);
   localparam int RowW  = $clog2(WINDOW_DEPTH);
   localparam int SsW   = $clog2(WINDOW_DEPTH + 2);

   // sequencer codes
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LOOK = 4'd1;
   localparam logic [3:0] S_RDP  = 4'd2;   // read previous row
   localparam logic [3:0] S_SP   = 4'd3;   // start interval division
   localparam logic [3:0] S_WP   = 4'd4;
   localparam logic [3:0] S_RDO  = 4'd5;   // read window start row
   localparam logic [3:0] S_SO   = 4'd6;
   localparam logic [3:0] S_WO   = 4'd7;
   localparam logic [3:0] S_SA   = 4'd8;   // average since first sample
   localparam logic [3:0] S_WA   = 4'd9;
   localparam logic [3:0] S_FIN  = 4'd10;  // commit, close sample, emit

   logic [3:0]        state_ff, state_in;

   // current item
   logic [ID_W-1:0]   id_ff;
   logic [CB-1:0]     rt_ff, tot_ff;
   logic              last_ff;
   logic [SlotW-1:0]  slot_ff;
   logic              has_slot_ff;
   logic              has_row_ff;
   logic [LOAD_W-1:0] win_ff, avg_ff;

   // history
   logic [CB-1:0]     snap_mem [WINDOW_DEPTH][TASK_SLOTS];
   logic              snap_vld_ff [WINDOW_DEPTH][TASK_SLOTS];
   logic [CB-1:0]     totals_ff [WINDOW_DEPTH];
   logic [CB-1:0]     start_rt_ff [TASK_SLOTS];
   logic [CB-1:0]     start_tot_ff;
   logic [LOAD_W-1:0] peak_ff [TASK_SLOTS];
   logic [RowW-1:0]   pos_ff;
   logic [SsW-1:0]    ss_ff;
   logic [TASK_SLOTS-1:0] seen_ff;

   // snapshot read port
   logic [RowW-1:0]   rd_row;
   logic [CB-1:0]     rd_data_ff;
   logic              rd_vld_ff;
   logic [CB-1:0]     rd_val;

   // output register
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   // unit hookups
   slot_rsp_type      slot_rsp;
   logic [SlotW-1:0]  slot_idx;
   logic [CntW-1:0]   slots_used;
   logic              slot_add;
   div_rsp_type       div_rsp;
   logic              div_start;
   logic [CB-1:0]     div_part, div_whole;

   logic [RowW-1:0]   prev_row, oldest_row;
   logic              can_emit;
   logic              commit;
   logic [TASK_SLOTS-1:0] seen_next;
   logic [CB-1:0]     rt_c, tot_c;

   // fit the 32-bit fields to the counter width
   always_comb begin
      rt_c  = '0;
      tot_c = '0;
      for (int i = 0; i < CB && i < FIELD_W; i++) begin
         rt_c[i]  = req_tdata[ID_W + i];
         tot_c[i] = req_tdata[ID_W + FIELD_W + i];
      end
   end

   assign prev_row   = (pos_ff == '0) ? RowW'(WINDOW_DEPTH - 1) : pos_ff - RowW'(1);
   assign oldest_row = (ss_ff >= SsW'(WINDOW_DEPTH)) ?
                       ((pos_ff == RowW'(WINDOW_DEPTH - 1)) ? '0 : pos_ff + RowW'(1)) : '0;
   assign rd_row     = (state_ff == S_RDO) ? oldest_row : prev_row;
   assign rd_val     = rd_vld_ff ? rd_data_ff : '0;

   assign can_emit   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == S_FIN) && (!has_row_ff || can_emit);
   assign req_tready = (state_ff == S_IDLE);
   assign slot_add   = (state_ff == S_LOOK) && !slot_rsp.hit && !slot_rsp.full;

   always_comb begin
      seen_next = seen_ff;
      if (has_slot_ff) seen_next[slot_ff] = 1'b1;
   end

   // divider operand select
   always_comb begin
      div_start = 1'b0;
      div_part  = rt_ff - rd_val;
      div_whole = tot_ff - totals_ff[prev_row];
      unique case (state_ff)
         S_SP: div_start = 1'b1;
         S_SO: begin
            div_start = 1'b1;
            div_whole = tot_ff - totals_ff[oldest_row];
         end
         S_SA: begin
            div_start = 1'b1;
            div_part  = rt_ff - start_rt_ff[slot_ff];
            div_whole = tot_ff - start_tot_ff;
         end
         default: ;
      endcase
   end

   tlwm_slots #(.TASK_SLOTS(TASK_SLOTS)) u_slots (
      .clock     (clock),
      .reset     (reset),
      .lookup_id (id_ff),
      .add       (slot_add),
      .rsp       (slot_rsp),
      .idx       (slot_idx),
      .used      (slots_used)
   );

   tlwm_div #(.COUNTER_BITS(COUNTER_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .part  (div_part),
      .whole (div_whole),
      .rsp   (div_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_LOOK;
         S_LOOK: begin
            if ((slot_rsp.hit || !slot_rsp.full) && (ss_ff != '0)) state_in = S_RDP;
            else state_in = S_FIN;
         end
         S_RDP:  state_in = S_SP;
         S_SP:   state_in = S_WP;
         S_WP:   if (div_rsp.done) state_in = S_RDO;
         S_RDO:  state_in = S_SO;
         S_SO:   state_in = S_WO;
         S_WO:   if (div_rsp.done) state_in = S_SA;
         S_SA:   state_in = S_WA;
         S_WA:   if (div_rsp.done) state_in = S_FIN;
         S_FIN:  if (commit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // snapshot store: registered read, write on commit
   always_ff @(posedge clock) begin
      rd_data_ff <= snap_mem[rd_row][slot_ff];
      if (commit && has_slot_ff) snap_mem[pos_ff][slot_ff] <= rt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         has_slot_ff  <= 1'b0;
         has_row_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         pos_ff       <= '0;
         ss_ff        <= '0;
         seen_ff      <= '0;
         start_tot_ff <= '0;
         for (int r = 0; r < WINDOW_DEPTH; r++) begin
            totals_ff[r] <= '0;
            for (int s = 0; s < TASK_SLOTS; s++) snap_vld_ff[r][s] <= 1'b0;
         end
         for (int s = 0; s < TASK_SLOTS; s++) begin
            start_rt_ff[s] <= '0;
            peak_ff[s]     <= '0;
         end
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= snap_vld_ff[rd_row][slot_ff];
         if (commit && has_row_ff) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;

         if (state_ff == S_LOOK) begin
            has_slot_ff <= slot_rsp.hit || !slot_rsp.full;
            has_row_ff  <= (slot_rsp.hit || !slot_rsp.full) && (ss_ff != '0);
         end

         // interval load feeds the running peak
         if (state_ff == S_WP && div_rsp.done && div_rsp.q > peak_ff[slot_ff])
            peak_ff[slot_ff] <= div_rsp.q;

         if (commit) begin
            if (has_slot_ff) begin
               snap_vld_ff[pos_ff][slot_ff] <= 1'b1;
               if (ss_ff == '0) start_rt_ff[slot_ff] <= rt_ff;
            end
            seen_ff <= last_ff ? '0 : seen_next;
            if (last_ff) begin
               // slots absent from this sample read as zero in this row
               for (int s = 0; s < TASK_SLOTS; s++) begin
                  if (s < int'(slots_used) && !seen_next[s]) begin
                     snap_vld_ff[pos_ff][s] <= 1'b0;
                     if (ss_ff == '0) start_rt_ff[s] <= '0;
                  end
               end
               totals_ff[pos_ff] <= tot_ff;
               if (ss_ff == '0) start_tot_ff <= tot_ff;
               if (ss_ff != SsW'(WINDOW_DEPTH + 1)) ss_ff <= ss_ff + SsW'(1);
               pos_ff <= (pos_ff == RowW'(WINDOW_DEPTH - 1)) ? '0 : pos_ff + RowW'(1);
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         id_ff   <= req_tdata[ID_W-1:0];
         rt_ff   <= rt_c;
         tot_ff  <= tot_c;
         last_ff <= req_tlast;
      end
      if (state_ff == S_LOOK) slot_ff <= slot_idx;
      if (state_ff == S_WO && div_rsp.done) win_ff <= div_rsp.q;
      if (state_ff == S_WA && div_rsp.done) avg_ff <= div_rsp.q;
      if (commit && has_row_ff)
         rsp_data_ff <= {2'b00, avg_ff, peak_ff[slot_ff], win_ff, id_ff};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ring bookkeeping stays in range
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < RowW'(WINDOW_DEPTH))
      else $error("ring position out of range");

   a_ss_range: assert property (@(posedge clock) disable iff (reset)
      ss_ff <= SsW'(WINDOW_DEPTH + 1))
      else $error("sample count past saturation");

   a_div_sat: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> div_rsp.q <= FULL_SCALE)
      else $error("load above full scale");

   a_row_ready: assert property (@(posedge clock) disable iff (reset)
      commit && has_row_ff |=> rsp_tvalid)
      else $error("committed row not presented");

   a_slots_cap: assert property (@(posedge clock) disable iff (reset)
      slots_used <= CntW'(TASK_SLOTS))
      else $error("slot count overflow");
endmodule
`default_nettype wire
